// ===== design/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants for the quadratic root solver
// Widths of the square-root and divider chains and the cell tag structs.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COEF_W      = 16;
	localparam int DELTA_PAIRS = 17;
	localparam int DW          = 2 * DELTA_PAIRS;          // discriminant bits
	localparam int RB          = DELTA_PAIRS + FRAC_BITS;  // sqrt result bits
	localparam int RW          = RB + 2;                   // sqrt remainder bits
	localparam int BW          = 17 + FRAC_BITS;           // -b * 2^F, signed
	localparam int NSW         = 19 + FRAC_BITS;           // numerator, signed
	localparam int NMW         = 18 + FRAC_BITS;           // numerator magnitude
	localparam int DENW        = 17;                       // |2a|
	localparam int DRW         = DENW + 1;                 // divider remainder
	localparam int ROOT_W      = 48;
	localparam int LATENCY     = 3 + RB + NMW;

	typedef enum logic [1:0] {
		ST_NOT_QUAD = 2'd0,
		ST_NO_ROOT  = 2'd1,
		ST_ONE_ROOT = 2'd2,
		ST_TWO_ROOT = 2'd3
	} status_t;

	// travels with a request through the sqrt chain
	typedef struct packed {
		logic                 valid;
		status_t              status;
		logic                 a_neg;
		logic [DENW-1:0]      den;
		logic signed [BW-1:0] base;
	} sq_tag_t;

	// travels with a request through the divider chain
	typedef struct packed {
		logic            valid;
		status_t         status;
		logic            neg_p;
		logic            neg_m;
		logic [DENW-1:0] den;
	} dv_tag_t;

endpackage

// ===== design/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the digit-by-digit square root
// Takes the next bit pair of the radicand, tries root*4+1, keeps one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  qrs_pkg::sq_tag_t       tag_in,
	input  logic [qrs_pkg::DW-1:0] d_in,
	input  logic [qrs_pkg::RW-1:0] rem_in,
	input  logic [qrs_pkg::RB-1:0] root_in,
	output qrs_pkg::sq_tag_t       tag_q,
	output logic [qrs_pkg::DW-1:0] d_q,
	output logic [qrs_pkg::RW-1:0] rem_q,
	output logic [qrs_pkg::RB-1:0] root_q
);

	logic [qrs_pkg::RW-1:0] rem_x;
	logic [qrs_pkg::RW-1:0] trial;
	logic                   ge;

	// bring down a pair and compare with the trial value
	always_comb begin
		rem_x = {rem_in[qrs_pkg::RW-3:0], d_in[qrs_pkg::DW-1 -: 2]};
		trial = {root_in, 2'b01};
		ge    = (rem_x >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		d_q    <= {d_in[qrs_pkg::DW-3:0], 2'b00};
		rem_q  <= ge ? (rem_x - trial) : rem_x;
		root_q <= {root_in[qrs_pkg::RB-2:0], ge};
	end

endmodule

// ===== design/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_div_cell: one quotient bit of two restoring divisions
// Both numerator magnitudes share the same divisor |2a|.
// ----------------------------------------------------------------------------
module qrs_div_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qrs_pkg::dv_tag_t         tag_in,
	input  logic [1:0][qrs_pkg::NMW-1:0] num_in,
	input  logic [1:0][qrs_pkg::DRW-1:0] rem_in,
	input  logic [1:0][qrs_pkg::NMW-1:0] quo_in,
	output qrs_pkg::dv_tag_t         tag_q,
	output logic [1:0][qrs_pkg::NMW-1:0] num_q,
	output logic [1:0][qrs_pkg::DRW-1:0] rem_q,
	output logic [1:0][qrs_pkg::NMW-1:0] quo_q
);

	logic [1:0][qrs_pkg::DRW-1:0] rem_x;
	logic [qrs_pkg::DRW-1:0]      den_x;
	logic [1:0]                   ge;

	// shift in the next numerator bit and try the subtract
	always_comb begin
		den_x = {1'b0, tag_in.den};
		for (int i = 0; i < 2; i++) begin
			rem_x[i] = {rem_in[i][qrs_pkg::DRW-2:0], num_in[i][qrs_pkg::NMW-1]};
			ge[i]    = (rem_x[i] >= den_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			num_q[i] <= {num_in[i][qrs_pkg::NMW-2:0], 1'b0};
			rem_q[i] <= ge[i] ? (rem_x[i] - den_x) : rem_x[i];
			quo_q[i] <= {quo_in[i][qrs_pkg::NMW-2:0], ge[i]};
		end
	end

endmodule

// ===== design/quadratic_root_solver_top.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_top: real roots of a*x^2 + b*x + c = 0
// Exact discriminant, fixed-point roots through a sqrt chain and divider chain.
// ----------------------------------------------------------------------------
// Usage:
//   Drive coef_a/coef_b/coef_c and pulse start; a request is taken on any
//   edge with start high and busy low. busy stays low: a new request can
//   enter every cycle and many are in flight at once.
//   Each request gives one result, shown for one cycle with done high:
//   root_status, root_plus and root_minus (signed, FRAC_BITS fraction bits).
//   Each request passes through the product register, the discriminant
//   register, one sqrt cell per root bit in the sqrt cell row, one divider
//   cell per quotient bit in the divider cell row and one output register.
//   Throughput is one request per cycle.
//   Roots are zero when a is zero or the discriminant is negative.
//   Reset clears all valid flags, so nothing in flight comes out afterward.
//   The receiver cannot stall: results are always taken in their cycle.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [15:0]           coef_a,
	input  logic signed [15:0]           coef_b,
	input  logic signed [15:0]           coef_c,
	output logic                         done,
	output logic [1:0]                   root_status,
	output logic signed [47:0]           root_plus,
	output logic signed [47:0]           root_minus
);

	localparam int RB  = qrs_pkg::RB;
	localparam int NMW = qrs_pkg::NMW;

	// stage 1: products
	logic                      vld_s1;
	logic signed [15:0]        a_s1;
	logic signed [15:0]        b_s1;
	logic signed [31:0]        bb_s1;
	logic signed [31:0]        ac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= coef_a;
		b_s1  <= coef_b;
		bb_s1 <= coef_b * coef_b;
		ac_s1 <= coef_a * coef_c;
	end

	// stage 2: discriminant, status, scaled -b and |2a|
	logic signed [34:0]            delta;
	logic signed [qrs_pkg::BW-1:0] b_ext;
	qrs_pkg::sq_tag_t              tag2;

	always_comb begin
		delta = 35'(bb_s1) - (35'(ac_s1) <<< 2);
		b_ext = qrs_pkg::BW'(b_s1);
		tag2.valid  = vld_s1;
		tag2.a_neg  = a_s1[15];
		tag2.den    = {(a_s1[15] ? (16'd0 - a_s1) : a_s1), 1'b0};
		tag2.base   = (qrs_pkg::BW'(0) - b_ext) <<< qrs_pkg::FRAC_BITS;
		if (a_s1 == 16'sd0) begin
			tag2.status = qrs_pkg::ST_NOT_QUAD;
		end else if (delta < 0) begin
			tag2.status = qrs_pkg::ST_NO_ROOT;
		end else if (delta == 0) begin
			tag2.status = qrs_pkg::ST_ONE_ROOT;
		end else begin
			tag2.status = qrs_pkg::ST_TWO_ROOT;
		end
	end

	qrs_pkg::sq_tag_t              sq_tag_s2;
	logic [qrs_pkg::DW-1:0]        sq_d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_tag_s2 <= '0;
		end else begin
			sq_tag_s2 <= tag2;
		end
	end

	always_ff @(posedge clk) begin
		sq_d_s2 <= delta[qrs_pkg::DW-1:0];
	end

	// sqrt cell row
	qrs_pkg::sq_tag_t              sq_tag [RB+1];
	logic [qrs_pkg::DW-1:0]        sq_d   [RB+1];
	logic [qrs_pkg::RW-1:0]        sq_rem [RB+1];
	logic [RB-1:0]                 sq_rt  [RB+1];

	assign sq_tag[0] = sq_tag_s2;
	assign sq_d[0]   = sq_d_s2;
	assign sq_rem[0] = '0;
	assign sq_rt[0]  = '0;

	for (genvar i = 0; i < RB; i++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tag_in  (sq_tag[i]),
			.d_in    (sq_d[i]),
			.rem_in  (sq_rem[i]),
			.root_in (sq_rt[i]),
			.tag_q   (sq_tag[i+1]),
			.d_q     (sq_d[i+1]),
			.rem_q   (sq_rem[i+1]),
			.root_q  (sq_rt[i+1])
		);
	end

	// numerators and their signs feed the divider row
	logic signed [qrs_pkg::NSW-1:0] np;
	logic signed [qrs_pkg::NSW-1:0] nm;
	logic signed [qrs_pkg::NSW-1:0] s_ext;
	qrs_pkg::dv_tag_t               dv_tag [NMW+1];
	logic [1:0][NMW-1:0]            dv_num [NMW+1];
	logic [1:0][qrs_pkg::DRW-1:0]   dv_rem [NMW+1];
	logic [1:0][NMW-1:0]            dv_quo [NMW+1];
	logic signed [qrs_pkg::NSW-1:0] np_abs;
	logic signed [qrs_pkg::NSW-1:0] nm_abs;

	always_comb begin
		s_ext  = qrs_pkg::NSW'({1'b0, sq_rt[RB]});
		np     = qrs_pkg::NSW'(sq_tag[RB].base) + s_ext;
		nm     = qrs_pkg::NSW'(sq_tag[RB].base) - s_ext;
		np_abs = np[qrs_pkg::NSW-1] ? -np : np;
		nm_abs = nm[qrs_pkg::NSW-1] ? -nm : nm;
		dv_tag[0].valid  = sq_tag[RB].valid;
		dv_tag[0].status = sq_tag[RB].status;
		dv_tag[0].den    = sq_tag[RB].den;
		dv_tag[0].neg_p  = np[qrs_pkg::NSW-1] ^ sq_tag[RB].a_neg;
		dv_tag[0].neg_m  = nm[qrs_pkg::NSW-1] ^ sq_tag[RB].a_neg;
		dv_num[0] = {nm_abs[NMW-1:0], np_abs[NMW-1:0]};
		dv_rem[0] = '0;
		dv_quo[0] = '0;
	end

	// divider cell row
	for (genvar j = 0; j < NMW; j++) begin : g_div
		qrs_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tag_in (dv_tag[j]),
			.num_in (dv_num[j]),
			.rem_in (dv_rem[j]),
			.quo_in (dv_quo[j]),
			.tag_q  (dv_tag[j+1]),
			.num_q  (dv_num[j+1]),
			.rem_q  (dv_rem[j+1]),
			.quo_q  (dv_quo[j+1])
		);
	end

	// output register: apply signs, zero when there is no root
	qrs_pkg::dv_tag_t               dv_last;
	logic signed [47:0]             qp;
	logic signed [47:0]             qm;
	logic                           has_root;

	always_comb begin
		dv_last  = dv_tag[NMW];
		qp       = 48'($signed({1'b0, dv_quo[NMW][0]}));
		qm       = 48'($signed({1'b0, dv_quo[NMW][1]}));
		has_root = (dv_last.status == qrs_pkg::ST_ONE_ROOT) ||
		           (dv_last.status == qrs_pkg::ST_TWO_ROOT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_last.valid;
		end
	end

	always_ff @(posedge clk) begin
		root_status <= dv_last.status;
		root_plus   <= !has_root ? '0 : (dv_last.neg_p ? -qp : qp);
		root_minus  <= !has_root ? '0 : (dv_last.neg_m ? -qm : qm);
	end

	assign busy = 1'b0;

`ifndef SYNTHESIS
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, qrs_pkg::LATENCY))
		else $error("result without matching request");
	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (root_status == qrs_pkg::ST_NOT_QUAD ||
		          root_status == qrs_pkg::ST_NO_ROOT))
		|-> (root_plus == '0 && root_minus == '0))
		else $error("nonzero root without real roots");
	a_double_root: assert property (@(posedge clk) disable iff (!arst_n)
		(done && root_status == qrs_pkg::ST_ONE_ROOT) |-> (root_plus == root_minus))
		else $error("double root fields differ");
`endif

endmodule
